FILE: src/atf_pkg.sv
// Shared types, codes and constants of the 2D affine transform engine.
// Used by atf_front, atf_sincos, atf_back and the top level.
package atf_pkg;

	// Fixed-point format
	localparam int FRAC_BITS  = 16;
	localparam int WORD_W     = 32;
	localparam int ANGLE_BITS = 16;
	localparam int OPND_W     = WORD_W + 1;
	localparam int PROD_W     = 2 * OPND_W;
	localparam int ACC_W      = PROD_W + 6;
	localparam int TRIG_W     = 34;
	localparam int CORDIC_STEPS = 30;
	localparam int STEP_W     = 5;

	localparam logic signed [OPND_W-1:0] ONE_Q = OPND_W'(1) << FRAC_BITS;
	localparam logic signed [WORD_W-1:0] ONE_W = WORD_W'(1) << FRAC_BITS;
	localparam logic signed [ACC_W-1:0]  RND_Q = ACC_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = TRIG_W'(652032874);

	// Operation codes
	localparam logic [2:0] OP_IDENTITY  = 3'd0;
	localparam logic [2:0] OP_TRANSLATE = 3'd1;
	localparam logic [2:0] OP_ROTATE    = 3'd2;
	localparam logic [2:0] OP_SCALE     = 3'd3;
	localparam logic [2:0] OP_REFLECT   = 3'd4;
	localparam logic [2:0] OP_SHEAR     = 3'd5;
	localparam logic [2:0] OP_VERTEX    = 3'd6;

	// Item classes assigned by the front end
	localparam logic [2:0] CLS_NOP    = 3'd0;
	localparam logic [2:0] CLS_IDENT  = 3'd1;
	localparam logic [2:0] CLS_SETUP  = 3'd2;
	localparam logic [2:0] CLS_ROTATE = 3'd3;
	localparam logic [2:0] CLS_VERTEX = 3'd4;

	// Destination kinds of a finished sum
	localparam logic [1:0] K_OFF = 2'd0;
	localparam logic [1:0] K_ENT = 2'd1;
	localparam logic [1:0] K_VTX = 2'd2;

	typedef struct packed {
		logic [2:0]               operation;
		logic signed [WORD_W-1:0] param_a;
		logic signed [WORD_W-1:0] param_b;
		logic signed [WORD_W-1:0] pos_x;
		logic signed [WORD_W-1:0] pos_y;
		logic [ANGLE_BITS-1:0]    angle;
		logic                     last_vertex;
	} in_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] out_x;
		logic signed [WORD_W-1:0] out_y;
		logic                     last;
		logic                     overflow;
	} out_item_t;

	typedef struct packed {
		logic [2:0] cls;
		in_item_t   item;
	} queue_item_t;

	typedef struct packed {
		logic                  start;
		logic [ANGLE_BITS-1:0] angle;
	} trig_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [OPND_W-1:0] cos_v;
		logic signed [OPND_W-1:0] sin_v;
	} trig_rsp_t;

	typedef struct packed {
		logic       valid;
		logic       first;
		logic       last;
		logic [1:0] kind;
		logic [2:0] dest;
	} mac_tag_t;

	function automatic logic signed [OPND_W-1:0] ext(input logic signed [WORD_W-1:0] v);
		ext = {v[WORD_W-1], v};
	endfunction

	// atan(2^-i) as a 32-bit fraction of a turn
	function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
		case (i)
			5'd0:  atan_turn = 32'h20000000;
			5'd1:  atan_turn = 32'h12E4051E;
			5'd2:  atan_turn = 32'h09FB385B;
			5'd3:  atan_turn = 32'h051111D4;
			5'd4:  atan_turn = 32'h028B0D43;
			5'd5:  atan_turn = 32'h0145D7E1;
			5'd6:  atan_turn = 32'h00A2F61E;
			5'd7:  atan_turn = 32'h00517C55;
			5'd8:  atan_turn = 32'h0028BE53;
			5'd9:  atan_turn = 32'h00145F2F;
			5'd10: atan_turn = 32'h000A2F98;
			5'd11: atan_turn = 32'h000517CC;
			5'd12: atan_turn = 32'h00028BE6;
			5'd13: atan_turn = 32'h000145F3;
			5'd14: atan_turn = 32'h0000A2F9;
			5'd15: atan_turn = 32'h0000517C;
			5'd16: atan_turn = 32'h000028BE;
			5'd17: atan_turn = 32'h0000145F;
			5'd18: atan_turn = 32'h00000A2F;
			5'd19: atan_turn = 32'h00000517;
			5'd20: atan_turn = 32'h0000028B;
			5'd21: atan_turn = 32'h00000145;
			5'd22: atan_turn = 32'h000000A2;
			5'd23: atan_turn = 32'h00000051;
			5'd24: atan_turn = 32'h00000028;
			5'd25: atan_turn = 32'h00000014;
			5'd26: atan_turn = 32'h0000000A;
			5'd27: atan_turn = 32'h00000005;
			5'd28: atan_turn = 32'h00000002;
			5'd29: atan_turn = 32'h00000001;
			default: atan_turn = 32'h0;
		endcase
	endfunction

endpackage

FILE: src/affine_2d_transform_engine.sv
// Top level of the 2D affine transform engine (3x3 homogeneous, Q16.16).
// Depends on atf_pkg, atf_front, atf_sincos, atf_back.
//
//   channel | signals                  | beat
//   cmd     | cmd_valid, cmd_ready, cmd | one operation or vertex
//   res     | res_valid, res_ready, res | one transformed vertex
//
// A vertex is handled in order: a pop of the queue, four products on the one
// shared 33x33 multiplier, a drain of the multiply/accumulate pipeline and a
// load of the result register. Set-up items take a pop, 16 products and a
// drain; rotation runs the CORDIC before the products. A four-entry queue
// accepts commands while the back end works, and the result register holds a
// beat while res_ready is low. Reset loads the identity matrix at once; no
// clearing pass.
module affine_2d_transform_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  atf_pkg::in_item_t  cmd,
	output logic               res_valid,
	input  logic               res_ready,
	output atf_pkg::out_item_t res
);
	import atf_pkg::*;

	logic        q_valid, q_pop;
	queue_item_t q_item;
	trig_req_t   trig_req;
	trig_rsp_t   trig_rsp;

	atf_front u_front (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
	);

	atf_sincos u_sincos (
		.clk(clk), .arst_n(arst_n), .req(trig_req), .rsp(trig_rsp)
	);

	atf_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
		.trig_req(trig_req), .trig_rsp(trig_rsp),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

`ifndef SYNTH
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("queue popped while empty");
	a_trig_not_instant: assert property (@(posedge clk) disable iff (!arst_n)
		trig_req.start |=> !trig_rsp.done) else $error("CORDIC finished too early");
	a_trig_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		trig_rsp.done |=> !trig_rsp.done) else $error("CORDIC done held");
`endif

endmodule

FILE: src/atf_front.sv
// Front end: accepts command beats, classifies them and queues them.
// Depends on atf_pkg.
module atf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  atf_pkg::in_item_t    cmd,
	output logic                 q_valid,
	input  logic                 q_pop,
	output atf_pkg::queue_item_t q_item
);
	import atf_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = 2;

	queue_item_t      fifo_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic [2:0]       cls;
	logic             push;

	// Classify by operation code
	always_comb begin
		unique case (cmd.operation) inside
			OP_IDENTITY:                                   cls = CLS_IDENT;
			OP_TRANSLATE, OP_SCALE, OP_REFLECT, OP_SHEAR: cls = CLS_SETUP;
			OP_ROTATE:                                     cls = CLS_ROTATE;
			OP_VERTEX:                                     cls = CLS_VERTEX;
			default:                                       cls = CLS_NOP;
		endcase
	end

	assign cmd_ready = (count_q != (PTR_W+1)'(DEPTH));
	assign push      = cmd_valid && cmd_ready;
	assign q_valid   = (count_q != '0);
	assign q_item    = fifo_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{cls: cls, item: cmd};
		end
	end

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (q_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !q_pop) count_q <= count_q + 1'b1;
			else if (!push && q_pop) count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: src/atf_sincos.sv
// Iterative CORDIC: sine and cosine of a fraction of a turn, one step a cycle.
// Depends on atf_pkg.
module atf_sincos (
	input  logic               clk,
	input  logic               arst_n,
	input  atf_pkg::trig_req_t req,
	output atf_pkg::trig_rsp_t rsp
);
	import atf_pkg::*;

	logic signed [TRIG_W-1:0] x_q, y_q, z_q;
	logic signed [TRIG_W-1:0] dx, dy, xn, yn, zn, xr, yr;
	logic [STEP_W-1:0]        i_q;
	logic                     busy_q, flip_q, done_q;
	logic signed [OPND_W-1:0] cos_q, sin_q;
	logic [31:0]              t_in, t_fold, t_add;
	logic                     fold;

	// Angle fold into the right half plane
	always_comb begin
		t_in   = {req.angle, {(32-ANGLE_BITS){1'b0}}};
		t_add  = t_in + 32'h4000_0000;
		fold   = t_add[31];
		t_fold = fold ? (t_in ^ 32'h8000_0000) : t_in;
	end

	// One rotation step and final rounding
	always_comb begin
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		if (!z_q[TRIG_W-1]) begin
			xn = x_q - dx;
			yn = y_q + dy;
			zn = z_q - TRIG_W'(atan_turn(i_q));
		end else begin
			xn = x_q + dx;
			yn = y_q - dy;
			zn = z_q + TRIG_W'(atan_turn(i_q));
		end
		xr = (xn + (TRIG_W'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
		yr = (yn + (TRIG_W'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == STEP_W'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= {{(TRIG_W-32){t_fold[31]}}, t_fold};
			flip_q <= fold;
		end else if (busy_q) begin
			x_q <= xn;
			y_q <= yn;
			z_q <= zn;
			if (i_q == STEP_W'(CORDIC_STEPS - 1)) begin
				cos_q <= OPND_W'(flip_q ? -xr : xr);
				sin_q <= OPND_W'(flip_q ? -yr : yr);
			end
		end
	end

	assign rsp = '{done: done_q, cos_v: cos_q, sin_v: sin_q};

endmodule

FILE: src/atf_back.sv
// Back end: matrix store, shared multiplier with accumulator, sequencer and
// result register. Depends on atf_pkg; drives atf_sincos through trig_req_t.
module atf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  atf_pkg::queue_item_t q_item,
	output atf_pkg::trig_req_t   trig_req,
	input  atf_pkg::trig_rsp_t   trig_rsp,
	output logic                 res_valid,
	input  logic                 res_ready,
	output atf_pkg::out_item_t   res
);
	import atf_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_TRIG  = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_SEND  = 3'd4;

	localparam logic [3:0] LAST_SETUP  = 4'd15;
	localparam logic [3:0] LAST_VERTEX = 4'd3;

	logic [2:0]               state_q;
	logic [3:0]               step_q;
	queue_item_t              cur_q;
	logic signed [WORD_W-1:0] mat_q [6];
	logic signed [WORD_W-1:0] next_q [6];
	logic signed [ACC_W-1:0]  off_q [2];
	logic                     sticky_q, msat_q, vsat_q;
	logic signed [WORD_W-1:0] vx_q, vy_q;
	logic                     res_valid_q;
	out_item_t                res_q;
	logic                     res_load;

	logic signed [OPND_W-1:0] opa, opb;
	logic signed [OPND_W-1:0] pa, pb, px, py, cv, sv;
	logic signed [OPND_W-1:0] a0, a1, b0, b1, coef;
	mac_tag_t                 tag_d, tag_s1, tag_s2;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q, bias, shifted;
	logic [3:0]               k;
	logic [2:0]               idx, mat_idx;
	logic                     row_sel;
	logic [1:0]               col;
	logic [ACC_W-WORD_W:0]    hi_bits;
	logic                     sat;
	logic signed [WORD_W-1:0] settled;
	logic                     is_vertex;

	assign is_vertex = (cur_q.cls == CLS_VERTEX);
	assign pa = ext(cur_q.item.param_a);
	assign pb = ext(cur_q.item.param_b);
	assign px = ext(cur_q.item.pos_x);
	assign py = ext(cur_q.item.pos_y);
	assign cv = trig_rsp.cos_v;
	assign sv = trig_rsp.sin_v;

	// Linear part of the elementary transform
	always_comb begin
		a0 = ONE_Q; a1 = '0; b0 = '0; b1 = ONE_Q;
		case (cur_q.item.operation)
			OP_ROTATE:  begin a0 = cv;     a1 = -sv; b0 = sv; b1 = cv; end
			OP_SCALE:   begin a0 = pa;     b1 = pb; end
			OP_REFLECT: begin a0 = -ONE_Q; b1 = -ONE_Q; end
			OP_SHEAR:   begin a1 = pa;     b0 = pb; end
			default:    ;
		endcase
	end

	// Operand select for the shared multiplier
	always_comb begin
		opa     = '0;
		opb     = '0;
		tag_d   = '0;
		k       = step_q - 4'd4;
		idx     = k[3:1];
		row_sel = (idx >= 3'd3);
		col     = row_sel ? 2'(idx - 3'd3) : idx[1:0];
		mat_idx = k[0] ? (3'd3 + {1'b0, col}) : {1'b0, col};
		coef    = row_sel ? (k[0] ? b1 : b0) : (k[0] ? a1 : a0);
		tag_d.valid = (state_q == ST_MUL);
		tag_d.first = !step_q[0];
		tag_d.last  = step_q[0];
		if (is_vertex) begin
			tag_d.kind = K_VTX;
			tag_d.dest = {2'b00, step_q[1]};
			case (step_q[1:0])
				2'd0:    begin opa = ext(mat_q[0]); opb = px; end
				2'd1:    begin opa = ext(mat_q[1]); opb = py; end
				2'd2:    begin opa = ext(mat_q[3]); opb = px; end
				default: begin opa = ext(mat_q[4]); opb = py; end
			endcase
		end else if (step_q < 4'd4) begin
			// offset column, kept at double scale
			tag_d.kind = K_OFF;
			tag_d.dest = {2'b00, step_q[1]};
			case (cur_q.item.operation)
				OP_TRANSLATE: if (!step_q[0]) begin
					opa = step_q[1] ? pb : pa; opb = ONE_Q;
				end
				OP_ROTATE: case (step_q[1:0])
					2'd0:    begin opa = px;  opb = ONE_Q - cv; end
					2'd1:    begin opa = py;  opb = sv; end
					2'd2:    begin opa = py;  opb = ONE_Q - cv; end
					default: begin opa = -px; opb = sv; end
				endcase
				OP_SCALE: if (!step_q[0]) begin
					opa = step_q[1] ? (ONE_Q - pb) : (ONE_Q - pa);
					opb = step_q[1] ? py : px;
				end
				OP_REFLECT: if (!step_q[0]) begin
					opa = step_q[1] ? (py <<< 1) : (px <<< 1); opb = ONE_Q;
				end
				OP_SHEAR: if (!step_q[0]) begin
					opa = step_q[1] ? -pb : -pa;
					opb = step_q[1] ? px : py;
				end
				default: ;
			endcase
		end else begin
			tag_d.kind = K_ENT;
			tag_d.dest = row_sel ? (3'd3 + {1'b0, col}) : {1'b0, col};
			opa = coef;
			opb = ext(mat_q[mat_idx]);
		end
	end

	// Starting value of a sum: rounding plus offset or translation term; zero for an offset
	always_comb begin
		bias = '0;
		case (tag_s1.kind)
			K_ENT: begin
				bias = RND_Q;
				if (tag_s1.dest == 3'd2) bias = RND_Q + off_q[0];
				else if (tag_s1.dest == 3'd5) bias = RND_Q + off_q[1];
			end
			K_VTX: begin
				bias = RND_Q + ((ACC_W'(tag_s1.dest[0] ? mat_q[5] : mat_q[2])) <<< FRAC_BITS);
			end
			default: ;
		endcase
	end

	// Round has been added already: shift and clamp
	always_comb begin
		shifted = acc_q >>> FRAC_BITS;
		hi_bits = shifted[ACC_W-1:WORD_W-1];
		sat     = !((&hi_bits) || !(|hi_bits));
		if (!sat) settled = shifted[WORD_W-1:0];
		else if (acc_q[ACC_W-1]) settled = {1'b1, {(WORD_W-1){1'b0}}};
		else settled = {1'b0, {(WORD_W-1){1'b1}}};
	end

	// Multiply, accumulate and write-back stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= tag_d;
			tag_s2 <= '{valid: tag_s1.valid && tag_s1.last, first: tag_s1.first,
				last: tag_s1.last, kind: tag_s1.kind, dest: tag_s1.dest};
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= opa * opb;
		if (tag_s1.valid) begin
			acc_q <= (tag_s1.first ? bias : acc_q) + ACC_W'(prod_s1);
		end
		if (tag_s2.valid) begin
			case (tag_s2.kind)
				K_OFF:   off_q[tag_s2.dest[0]] <= acc_q;
				K_ENT:   next_q[tag_s2.dest] <= settled;
				default: begin
					if (tag_s2.dest[0]) vy_q <= settled;
					else vx_q <= settled;
				end
			endcase
		end
		if (state_q == ST_IDLE) begin
			cur_q <= q_item;
		end
	end

	// Sequencer, matrix store and result register
	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign trig_req = '{start: q_pop && (q_item.cls == CLS_ROTATE), angle: q_item.item.angle};
	assign res_load = (state_q == ST_SEND) && (!res_valid_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			mat_q       <= '{ONE_W, '0, '0, '0, ONE_W, '0};
			sticky_q    <= 1'b0;
			msat_q      <= 1'b0;
			vsat_q      <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_load) res_valid_q <= 1'b1;
			else if (res_valid_q && res_ready) res_valid_q <= 1'b0;
			if (tag_s2.valid && tag_s2.kind == K_ENT && sat) msat_q <= 1'b1;
			if (tag_s2.valid && tag_s2.kind == K_VTX && sat) vsat_q <= 1'b1;
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					msat_q <= 1'b0;
					vsat_q <= 1'b0;
					if (q_valid) begin
						case (q_item.cls)
							CLS_IDENT: begin
								mat_q    <= '{ONE_W, '0, '0, '0, ONE_W, '0};
								sticky_q <= 1'b0;
							end
							CLS_ROTATE: state_q <= ST_TRIG;
							CLS_SETUP, CLS_VERTEX: state_q <= ST_MUL;
							default: ;
						endcase
					end
				end
				ST_TRIG: if (trig_rsp.done) state_q <= ST_MUL;
				ST_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == (is_vertex ? LAST_VERTEX : LAST_SETUP)) state_q <= ST_DRAIN;
				end
				ST_DRAIN: if (!tag_s1.valid && !tag_s2.valid) begin
					if (is_vertex) begin
						state_q <= ST_SEND;
					end else begin
						mat_q    <= next_q;
						sticky_q <= sticky_q | msat_q;
						state_q  <= ST_IDLE;
					end
				end
				ST_SEND: if (res_load) begin
					res_q <= '{out_x: vx_q, out_y: vy_q, last: cur_q.item.last_vertex,
						overflow: vsat_q | sticky_q};
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// Testbench of affine_2d_transform_engine: random and directed command beats,
// with an in-order predictor of the matrix and the vertex results.
// Depends on atf_pkg and the engine RTL only.
module testbench;
	import atf_pkg::*;

	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam longint ONE = 64'sd65536;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	in_item_t  cmd = '0;
	logic      res_valid;
	logic      res_ready = 1'b0;
	out_item_t res;

	in_item_t  pending_cmds[$];
	out_item_t expected_vertices[$];
	longint    matrix[6];
	bit        sticky_sat;
	int        mismatches = 0;
	int        idle_cycles = 0;
	int        burst_left = 0;
	int        gap_left = 0;
	int        stall_mode = 0;
	int        stall_count = 0;

	affine_2d_transform_engine DUT (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	always #5 clk = ~clk;

	// Predictor arithmetic
	function automatic logic signed [127:0] wmul(longint a, longint b);
		logic signed [127:0] wa, wb;
		wa = a;
		wb = b;
		return wa * wb;
	endfunction

	// Round half up by 16 bits, then clamp to a signed range of the given width
	function automatic longint round_clamp(logic signed [127:0] acc, int bits, inout bit sat);
		logic signed [127:0] sh, maxv, minv;
		sh = (acc + 128'sd32768) >>> 16;
		maxv = (128'sd1 <<< (bits - 1)) - 1;
		minv = -maxv - 1;
		if (sh > maxv) begin
			sat = 1'b1;
			return longint'(maxv);
		end
		if (sh < minv) begin
			sat = 1'b1;
			return longint'(minv);
		end
		return longint'(sh);
	endfunction

	function automatic void cordic_sincos(logic [15:0] angle, output longint cv, output longint sv);
		logic [31:0] turn_atan[30];
		logic [31:0] t;
		bit          flip;
		longint      x, y, z, dx, dy;
		turn_atan = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
			32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
			32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
			32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
			32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
			32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001};
		t = {angle, 16'h0};
		flip = 1'b0;
		if (32'(t + 32'h40000000) >= 32'h80000000) begin
			t = t - 32'h80000000;
			flip = 1'b1;
		end
		z = longint'($signed(t));
		x = 652032874;
		y = 0;
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(turn_atan[i]);
			end else begin
				x += dx; y -= dy; z += longint'(turn_atan[i]);
			end
		end
		x = (x + (64'sd1 <<< 13)) >>> 14;
		y = (y + (64'sd1 <<< 13)) >>> 14;
		cv = flip ? -x : x;
		sv = flip ? -y : y;
	endfunction

	// M <- T * M; offsets come at twice the fraction scale
	function automatic void apply_transform(longint a0, longint a1, logic signed [127:0] off0,
			longint b0, longint b1, logic signed [127:0] off1);
		longint              nxt[6];
		logic signed [127:0] acc;
		bit                  sat;
		sat = 1'b0;
		for (int c = 0; c < 3; c++) begin
			acc = wmul(a0, matrix[c]) + wmul(a1, matrix[3+c]) + ((c == 2) ? off0 : 128'sd0);
			nxt[c] = round_clamp(acc, 32, sat);
			acc = wmul(b0, matrix[c]) + wmul(b1, matrix[3+c]) + ((c == 2) ? off1 : 128'sd0);
			nxt[3+c] = round_clamp(acc, 32, sat);
		end
		matrix = nxt;
		if (sat)
			sticky_sat = 1'b1;
	endfunction

	function automatic void load_identity();
		matrix = '{ONE, 0, 0, 0, ONE, 0};
		sticky_sat = 1'b0;
	endfunction

	// Advance the predicted state by one accepted command
	function automatic void predict_command(in_item_t it);
		longint    pa, pb, px, py, cv, sv;
		bit        sat;
		out_item_t o;
		pa = it.param_a; pb = it.param_b; px = it.pos_x; py = it.pos_y;
		sat = 1'b0;
		case (it.operation)
			OP_IDENTITY: load_identity();
			OP_TRANSLATE: apply_transform(ONE, 0, wmul(pa, ONE), 0, ONE, wmul(pb, ONE));
			OP_ROTATE: begin
				cordic_sincos(it.angle, cv, sv);
				apply_transform(cv, -sv, wmul(px, ONE - cv) + wmul(py, sv),
					sv, cv, wmul(py, ONE - cv) + wmul(-px, sv));
			end
			OP_SCALE: apply_transform(pa, 0, wmul(ONE - pa, px), 0, pb, wmul(ONE - pb, py));
			OP_REFLECT: apply_transform(-ONE, 0, wmul(2 * px, ONE), 0, -ONE, wmul(2 * py, ONE));
			OP_SHEAR: apply_transform(ONE, pa, wmul(-pa, py), pb, ONE, wmul(-pb, px));
			OP_VERTEX: begin
				o.out_x = 32'(round_clamp(wmul(matrix[0], px) + wmul(matrix[1], py)
					+ wmul(matrix[2], ONE), 32, sat));
				o.out_y = 32'(round_clamp(wmul(matrix[3], px) + wmul(matrix[4], py)
					+ wmul(matrix[5], ONE), 32, sat));
				o.last = it.last_vertex;
				o.overflow = sat | sticky_sat;
				expected_vertices.push_back(o);
			end
			default: ;
		endcase
	endfunction

	// Stimulus value: mostly modest Q16.16, sometimes any 32-bit pattern
	function automatic logic [31:0] rand_q();
		int k;
		k = $urandom_range(0, 9);
		if (k < 2)
			return $urandom;
		if (k < 4)
			return 32'($signed($urandom_range(0, 32'h00060000)) - 32'sh00030000);
		return 32'($signed($urandom_range(0, 32'h04000000)) - 32'sh02000000);
	endfunction

	function automatic in_item_t make_item(logic [2:0] op, logic [31:0] a, logic [31:0] b,
			logic [31:0] x, logic [31:0] y, logic [15:0] ang, logic lv);
		in_item_t it;
		it.operation = op; it.param_a = a; it.param_b = b;
		it.pos_x = x; it.pos_y = y; it.angle = ang; it.last_vertex = lv;
		return it;
	endfunction

	// Command driver: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		in_item_t nxt_cmd;
		logic     nxt_valid;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else begin
			nxt_cmd = cmd;
			nxt_valid = cmd_valid;
			if (cmd_valid && cmd_ready) begin
				predict_command(cmd);
				void'(pending_cmds.pop_front());
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_cmds.size() > 0) begin
					nxt_valid = 1'b1;
					nxt_cmd = pending_cmds[0];
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
					end
				end
			end
			cmd_valid <= nxt_valid;
			cmd <= nxt_cmd;
		end
	end

	// Result side: stall pattern switches mode every so often
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (stall_count == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_count = $urandom_range(20, 120);
			end
			stall_count--;
			case (stall_mode)
				0: res_ready <= 1'b1;
				1: res_ready <= $urandom_range(0, 1);
				2: res_ready <= ($urandom_range(0, 7) == 0);
				default: res_ready <= (stall_count % 16) < 4;
			endcase
		end
	end

	// Result checker
	always @(posedge clk) begin
		out_item_t exp_v;
		if (arst_n && res_valid && res_ready) begin
			if (expected_vertices.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: x=%h y=%h last=%b ovf=%b",
						res.out_x, res.out_y, res.last, res.overflow);
			end else begin
				exp_v = expected_vertices.pop_front();
				if (res.out_x !== exp_v.out_x || res.out_y !== exp_v.out_y
						|| res.last !== exp_v.last || res.overflow !== exp_v.overflow) begin
					mismatches++;
					if (mismatches <= 10)
						$display("vertex mismatch: exp x=%h y=%h last=%b ovf=%b, got x=%h y=%h last=%b ovf=%b",
							exp_v.out_x, exp_v.out_y, exp_v.last, exp_v.overflow,
							res.out_x, res.out_y, res.last, res.overflow);
				end
			end
		end
	end

	// Watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("affine_2d_transform_engine test failed");
			$finish;
		end
	end

	initial begin
		int          k;
		logic [2:0]  op;
		load_identity();
		// Directed: extremes, every operation, saturation, unused code
		pending_cmds.push_back(make_item(OP_VERTEX, 0, 0, 32'h7FFFFFFF, 32'h80000000, 0, 1));
		pending_cmds.push_back(make_item(OP_VERTEX, '1, '1, 32'h80000000, 32'h7FFFFFFF, '1, 0));
		pending_cmds.push_back(make_item(OP_TRANSLATE, 32'h00018000, 32'hFFFE0000, 0, 0, 0, 0));
		pending_cmds.push_back(make_item(OP_VERTEX, 0, 0, 32'h00010000, 32'h00020000, 0, 1));
		pending_cmds.push_back(make_item(OP_ROTATE, 0, 0, 32'h00010000, 0, 16'h4000, 0));
		pending_cmds.push_back(make_item(OP_VERTEX, 0, 0, 32'h00030000, 0, 0, 0));
		pending_cmds.push_back(make_item(OP_ROTATE, 0, 0, 0, 32'h00010000, 16'h8000, 0));
		pending_cmds.push_back(make_item(OP_ROTATE, 0, 0, 0, 0, 16'hC000, 0));
		pending_cmds.push_back(make_item(OP_ROTATE, 0, 0, 32'hFFFF0000, 0, 16'hFFFF, 0));
		pending_cmds.push_back(make_item(OP_VERTEX, 0, 0, 32'h00010000, 32'h00010000, 0, 1));
		pending_cmds.push_back(make_item(OP_SCALE, 32'h00020000, 32'hFFFF8000, 32'h00010000,
			32'hFFFF0000, 0, 0));
		pending_cmds.push_back(make_item(OP_REFLECT, 0, 0, 32'h00008000, 32'hFFFFC000, 0, 0));
		pending_cmds.push_back(make_item(OP_SHEAR, 32'h00004000, 32'hFFFFC000, 32'h00010000,
			32'h00020000, 0, 0));
		pending_cmds.push_back(make_item(OP_UNUSED, '1, '1, '1, '1, '1, 1));
		pending_cmds.push_back(make_item(OP_VERTEX, 0, 0, 32'h00050000, 32'hFFFB0000, 0, 1));
		// Vertex saturation without matrix saturation
		pending_cmds.push_back(make_item(OP_IDENTITY, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_item(OP_TRANSLATE, 32'h7FFF0000, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_item(OP_VERTEX, 0, 0, 32'h7FFF0000, 0, 0, 0));
		pending_cmds.push_back(make_item(OP_VERTEX, 0, 0, 0, 0, 0, 1));
		// Matrix saturation sets the sticky flag; identity clears it
		pending_cmds.push_back(make_item(OP_SCALE, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0));
		pending_cmds.push_back(make_item(OP_SCALE, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 0));
		pending_cmds.push_back(make_item(OP_VERTEX, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_item(OP_IDENTITY, '1, '1, '1, '1, '1, 1));
		pending_cmds.push_back(make_item(OP_VERTEX, 0, 0, 32'h00010000, 0, 0, 1));
		// Random: vertex groups between short chains of set-up operations
		for (int n = 0; n < 450; n++) begin
			k = $urandom_range(0, 99);
			if (k < 50) op = OP_VERTEX;
			else if (k < 56) op = OP_IDENTITY;
			else if (k < 58) op = OP_UNUSED;
			else op = 3'($urandom_range(OP_TRANSLATE, OP_SHEAR));
			pending_cmds.push_back(make_item(op, rand_q(), rand_q(), rand_q(), rand_q(),
				16'($urandom), 1'($urandom)));
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_cmds.size() == 0 && !cmd_valid && expected_vertices.size() == 0);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_vertices.size() == 0)
			$display("affine_2d_transform_engine test passed");
		else
			$display("affine_2d_transform_engine test failed");
		$finish;
	end

endmodule

FILE: sim.f
src/atf_pkg.sv
src/atf_front.sv
src/atf_sincos.sv
src/atf_back.sv
src/affine_2d_transform_engine.sv
sim/testbench.sv
